// File: design/dqp_pkg.sv
// Package: shared types and constants of the DNS question parser.
`timescale 1ns / 1ps
`default_nettype none
package dqp_pkg;

  localparam int unsigned MAX_NAME   = 256;
  localparam int unsigned FIXED_TAIL = 4;
  localparam int unsigned MAX_LABEL  = 63;
  localparam int unsigned OFF_W      = 9;
  localparam int unsigned LBL_W      = 6;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
  localparam logic [1:0] STATUS_BAD_LBL = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [15:0] buffer_size;
  } dqp_in_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             char_valid;
    logic             done_res;
    logic [1:0]       status;
    logic [15:0]      qtype;
    logic [15:0]      qclass;
    logic [OFF_W-1:0] bytes_consumed;
  } dqp_out_t;

endpackage
`default_nettype wire

// File: design/dqp_in_reg.sv
// Input register: holds one accepted transaction until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module dqp_in_reg (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  dqp_pkg::dqp_in_t in_data_i,
  output logic            item_valid_o,
  output dqp_pkg::dqp_in_t item_o,
  input  wire             item_take_i
);

  logic             valid_q;
  dqp_pkg::dqp_in_t data_q;

  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (item_take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

// File: design/dqp_parse.sv
// Parser: phase machine, name/type/class tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module dqp_parse (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              item_valid_i,
  input  dqp_pkg::dqp_in_t item_i,
  output logic             item_take_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output dqp_pkg::dqp_out_t out_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_LABEL    = 3'd2,
    PH_TYPE_HI  = 3'd3,
    PH_TYPE_LO  = 3'd4,
    PH_CLASS_HI = 3'd5,
    PH_CLASS_LO = 3'd6
  } phase_e;

  localparam int unsigned SUM_W = 17;

  phase_e                      ph_q, ph_d;
  logic [dqp_pkg::LBL_W-1:0]   lab_q, lab_d;
  logic [dqp_pkg::OFF_W-1:0]   off_q, off_d;
  logic [15:0]                 lim_q, lim_d;
  logic [15:0]                 type_q, type_d;
  logic [7:0]                  chi_q, chi_d;
  logic                        out_valid_q;
  dqp_pkg::dqp_out_t           out_q, res;

  phase_e                      ph;
  logic [dqp_pkg::OFF_W-1:0]   off, off_inc;
  logic [dqp_pkg::LBL_W-1:0]   lab, lab_dec;
  logic [SUM_W-1:0]            lbl_end, tail_end;
  logic [7:0]                  b;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    b       = item_i.data_byte;
    res     = '0;
    ph      = item_i.first ? PH_LEN : ph_q;
    off     = item_i.first ? '0 : off_q;
    lab     = item_i.first ? '0 : lab_q;
    lim_d   = item_i.first ? item_i.buffer_size : lim_q;
    type_d  = item_i.first ? 16'h0 : type_q;
    chi_d   = item_i.first ? 8'h0 : chi_q;
    ph_d    = ph;
    off_d   = off;
    lab_d   = lab;
    off_inc = off + 1'b1;
    lab_dec = lab - 1'b1;
    lbl_end = SUM_W'(off) + SUM_W'(b) + 1'b1;
    tail_end = SUM_W'(off) + SUM_W'(dqp_pkg::FIXED_TAIL);

    if (item_i.first && (item_i.buffer_size < 16'(dqp_pkg::FIXED_TAIL))) begin
      res.done_res = 1'b1;
      res.status   = dqp_pkg::STATUS_NO_ROOM;
      ph_d         = PH_IDLE;
    end else begin
      unique case (ph)
        PH_LEN: begin
          if (b == 8'h0) begin
            if (tail_end >= SUM_W'(lim_d)) begin
              res.done_res       = 1'b1;
              res.status         = dqp_pkg::STATUS_NO_ROOM;
              res.bytes_consumed = off_inc;
              ph_d               = PH_IDLE;
            end else begin
              ph_d  = PH_TYPE_HI;
              off_d = off_inc;
            end
          end else if (b > 8'(dqp_pkg::MAX_LABEL)) begin
            res.done_res       = 1'b1;
            res.status         = dqp_pkg::STATUS_BAD_LBL;
            res.bytes_consumed = off;
            ph_d               = PH_IDLE;
          end else if (lbl_end >= SUM_W'(lim_d) ||
                       lbl_end >= SUM_W'(dqp_pkg::MAX_NAME)) begin
            res.done_res       = 1'b1;
            res.status         = dqp_pkg::STATUS_NO_ROOM;
            res.bytes_consumed = off;
            ph_d               = PH_IDLE;
          end else begin
            res.out_char   = dqp_pkg::DOT_CHAR;
            res.char_valid = 1'b1;
            lab_d          = b[dqp_pkg::LBL_W-1:0];
            ph_d           = PH_LABEL;
            off_d          = off_inc;
          end
        end
        PH_LABEL: begin
          res.out_char   = b;
          res.char_valid = 1'b1;
          lab_d          = lab_dec;
          if (lab_dec == '0) begin
            ph_d = PH_LEN;
          end
          off_d = off_inc;
        end
        PH_TYPE_HI: begin
          type_d = {b, 8'h0};
          ph_d   = PH_TYPE_LO;
          off_d  = off_inc;
        end
        PH_TYPE_LO: begin
          type_d = {type_d[15:8], b};
          ph_d   = PH_CLASS_HI;
          off_d  = off_inc;
        end
        PH_CLASS_HI: begin
          chi_d = b;
          ph_d  = PH_CLASS_LO;
          off_d = off_inc;
        end
        PH_CLASS_LO: begin
          res.qtype          = type_d;
          res.qclass         = {chi_d, b};
          res.done_res       = 1'b1;
          res.status         = dqp_pkg::STATUS_OK;
          res.bytes_consumed = off_inc;
          ph_d               = PH_IDLE;
          off_d              = off_inc;
        end
        default: begin
          ph_d = ph;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      lab_q       <= '0;
      off_q       <= '0;
      lim_q       <= '0;
      type_q      <= '0;
      chi_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (item_take_o) begin
      ph_q        <= ph_d;
      lab_q       <= lab_d;
      off_q       <= off_d;
      lim_q       <= lim_d;
      type_q      <= type_d;
      chi_q       <= chi_d;
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |=> out_valid_q)
    else $error("taken transaction produced no result");

  a_char_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.char_valid && out_q.done_res))
    else $error("name character reported together with done");

  a_error_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != dqp_pkg::STATUS_OK) |-> out_q.done_res)
    else $error("error status without done");

  a_label_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_LABEL) |-> (lab_q != '0))
    else $error("label phase with no label bytes left");
`endif

endmodule
`default_nettype wire

// File: design/dns_question_parser.sv
// Top level: DNS question section parser, one byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
// Takes the bytes of a DNS question one per input transaction; the byte with
// first set starts a new question and samples buffer_size. Every accepted byte
// yields exactly one result: a '.' for each label-length byte, the label bytes
// unchanged, and on the last class byte done with qtype, qclass and the number
// of bytes read. Errors (no room, label length above 63) end the question with
// done and a nonzero status; bytes without first while idle give an all-zero
// result. Throughput is one byte per clock cycle while the output is not
// stalled; a byte passes through the input register, then the parse logic
// into the result register. Both sides are registered, so a stalled output
// does not block the input until both registers are full.
module dns_question_parser (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  dqp_pkg::dqp_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output dqp_pkg::dqp_out_t out_data_o
);

  logic             item_valid;
  logic             item_take;
  dqp_pkg::dqp_in_t item;

  dqp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  dqp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// File: test/dns_question_parser_checker.sv
// Checker: predicts DNS question parser results and compares them on the output channel.
`timescale 1ns / 1ps
module dns_question_parser_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  dqp_pkg::dqp_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dqp_pkg::dqp_out_t out_data_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                bytes_in_o,
  output int                names_ok_o,
  output int                no_room_o,
  output int                bad_label_o,
  output int                chars_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LENGTH,
    ST_LABEL,
    ST_TYPE_HI,
    ST_TYPE_LO,
    ST_CLASS_HI,
    ST_CLASS_LO
  } parse_state_e;

  parse_state_e              state;
  logic [dqp_pkg::LBL_W-1:0] label_cnt;
  logic [dqp_pkg::OFF_W-1:0] offset;
  logic [15:0]               limit;
  logic [15:0]               type_acc;
  logic [7:0]                class_hi;

  dqp_pkg::dqp_out_t expected_results[$];
  dqp_pkg::dqp_out_t predicted;
  dqp_pkg::dqp_out_t observed;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches_o++;
  endtask

  function automatic dqp_pkg::dqp_out_t close_question(dqp_pkg::dqp_out_t r,
                                                       logic [1:0] st, int count);
    r.done_res       = 1'b1;
    r.status         = st;
    r.bytes_consumed = dqp_pkg::OFF_W'(count);
    state            = ST_IDLE;
    return r;
  endfunction

  function automatic dqp_pkg::dqp_out_t parse_byte(dqp_pkg::dqp_in_t it);
    dqp_pkg::dqp_out_t r;
    int                o;
    int                b;
    r = '0;
    b = it.data_byte;
    if (it.first) begin
      limit     = it.buffer_size;
      offset    = '0;
      label_cnt = '0;
      type_acc  = '0;
      class_hi  = '0;
      state     = ST_LENGTH;
      if (limit < dqp_pkg::FIXED_TAIL) return close_question(r, dqp_pkg::STATUS_NO_ROOM, 0);
    end
    o = offset;
    case (state)
      ST_LENGTH: begin
        if (b == 0) begin
          if (o + int'(dqp_pkg::FIXED_TAIL) >= int'(limit))
            return close_question(r, dqp_pkg::STATUS_NO_ROOM, o + 1);
          state = ST_TYPE_HI;
        end else if (b > int'(dqp_pkg::MAX_LABEL)) begin
          return close_question(r, dqp_pkg::STATUS_BAD_LBL, o);
        end else if (o + b + 1 >= int'(limit) || o + b + 1 >= int'(dqp_pkg::MAX_NAME)) begin
          return close_question(r, dqp_pkg::STATUS_NO_ROOM, o);
        end else begin
          r.out_char   = dqp_pkg::DOT_CHAR;
          r.char_valid = 1'b1;
          label_cnt    = it.data_byte[dqp_pkg::LBL_W-1:0];
          state        = ST_LABEL;
        end
      end
      ST_LABEL: begin
        r.out_char   = it.data_byte;
        r.char_valid = 1'b1;
        label_cnt    = label_cnt - 1'b1;
        if (label_cnt == '0) state = ST_LENGTH;
      end
      ST_TYPE_HI: begin
        type_acc = {it.data_byte, 8'h00};
        state    = ST_TYPE_LO;
      end
      ST_TYPE_LO: begin
        type_acc = {type_acc[15:8], it.data_byte};
        state    = ST_CLASS_HI;
      end
      ST_CLASS_HI: begin
        class_hi = it.data_byte;
        state    = ST_CLASS_LO;
      end
      ST_CLASS_LO: begin
        r.qtype  = type_acc;
        r.qclass = {class_hi, it.data_byte};
        offset   = dqp_pkg::OFF_W'(o + 1);
        return close_question(r, dqp_pkg::STATUS_OK, o + 1);
      end
      default: return r;
    endcase
    offset = dqp_pkg::OFF_W'(o + 1);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state        = ST_IDLE;
      label_cnt    = '0;
      offset       = '0;
      limit        = '0;
      type_acc     = '0;
      class_hi     = '0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
      bytes_in_o   = 0;
      names_ok_o   = 0;
      no_room_o    = 0;
      bad_label_o  = 0;
      chars_o      = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predicted = parse_byte(in_data_i);
        expected_results.push_back(predicted);
        bytes_in_o++;
        if (predicted.char_valid) chars_o++;
        if (predicted.done_res) begin
          case (predicted.status)
            dqp_pkg::STATUS_OK:      names_ok_o++;
            dqp_pkg::STATUS_NO_ROOM: no_room_o++;
            default:                 bad_label_o++;
          endcase
        end
      end
      if (out_valid_i && out_ready_i) begin
        observed = out_data_i;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(observed), 32'd0);
        end else begin
          predicted = expected_results.pop_front();
          if (observed.out_char != predicted.out_char)
            report_mismatch("out_char", 32'(observed.out_char), 32'(predicted.out_char));
          if (observed.char_valid != predicted.char_valid)
            report_mismatch("char_valid", 32'(observed.char_valid),
                            32'(predicted.char_valid));
          if (observed.done_res != predicted.done_res)
            report_mismatch("done_res", 32'(observed.done_res), 32'(predicted.done_res));
          if (observed.status != predicted.status)
            report_mismatch("status", 32'(observed.status), 32'(predicted.status));
          if (observed.qtype != predicted.qtype)
            report_mismatch("qtype", 32'(observed.qtype), 32'(predicted.qtype));
          if (observed.qclass != predicted.qclass)
            report_mismatch("qclass", 32'(observed.qclass), 32'(predicted.qclass));
          if (observed.bytes_consumed != predicted.bytes_consumed)
            report_mismatch("bytes_consumed", 32'(observed.bytes_consumed),
                            32'(predicted.bytes_consumed));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: test/dns_question_parser_tb.sv
// Testbench top: drives DNS question bytes into the parser and gives the verdict.
`timescale 1ns / 1ps
module dns_question_parser_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT_ITEM = 400;
  localparam int RANDOM_ITEMS = 1350;

  typedef enum int {Q_CLEAN, Q_LONG, Q_BAD_LABEL, Q_CUT, Q_NOISE} question_kind_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  dqp_pkg::dqp_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  dqp_pkg::dqp_out_t out_data;

  int mismatches;
  int pending;
  int bytes_in;
  int names_ok;
  int no_room;
  int bad_label;
  int chars;

  int               cycles = 0;
  int               burst_left;
  bit               hold_req;
  bit               hold_done;
  dqp_pkg::dqp_in_t stim_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dns_question_parser u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  dns_question_parser_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .bytes_in_o   (bytes_in),
    .names_ok_o   (names_ok),
    .no_room_o    (no_room),
    .bad_label_o  (bad_label),
    .chars_o      (chars)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("dns_question_parser test failed");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic f, input logic [15:0] sz);
    dqp_pkg::dqp_in_t it;
    it.data_byte   = b;
    it.first       = f;
    it.buffer_size = f ? sz : 16'($urandom);
    stim_q.push_back(it);
  endtask

  task automatic add_question(input question_kind_e kind);
    logic [7:0]  seq[$];
    int          len_pos[$];
    int          nlab;
    int          len;
    int          total;
    int          n;
    logic [15:0] sz;
    if (kind == Q_NOISE) begin
      if ($urandom_range(0, 1) == 1) add_byte(8'($urandom), 1'b1, 16'($urandom_range(0, 7)));
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom), 1'b0, 16'h0);
      return;
    end
    nlab = (kind == Q_LONG) ? $urandom_range(4, 6) : $urandom_range(0, 4);
    if (kind == Q_BAD_LABEL && nlab == 0) nlab = 1;
    for (int i = 0; i < nlab; i++) begin
      if (kind == Q_LONG) len = $urandom_range(50, 63);
      else len = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(1, 10);
      len_pos.push_back(seq.size());
      seq.push_back(8'(len));
      repeat (len) seq.push_back(8'($urandom));
    end
    if (kind == Q_BAD_LABEL) seq[len_pos[$urandom_range(0, nlab - 1)]] = 8'($urandom_range(64, 255));
    seq.push_back(8'h00);
    repeat (4) seq.push_back(8'($urandom));
    total = seq.size();
    case ($urandom_range(0, 4))
      0, 1:    sz = 16'(total);
      2, 3:    sz = 16'($urandom_range(total, 65535));
      default: sz = 16'($urandom_range(0, total - 1));
    endcase
    n = (kind == Q_CUT) ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < n; i++) add_byte(seq[i], i == 0, sz);
  endtask

  task automatic send_item(input dqp_pkg::dqp_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  initial begin : receiver
    int         mode;
    int         left;
    logic [7:0] pat;
    out_ready = 1'b0;
    mode      = 0;
    left      = 0;
    pat       = '0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
        pat  = 8'($urandom);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
      endcase
    end
  end

  initial begin : stimulus
    int directed;
    int pick;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;

    add_byte(8'hFF, 1'b0, 16'h0);                  // stray byte while idle
    add_byte(8'h01, 1'b1, 16'h0000);               // buffer too small for the tail
    add_byte(8'h01, 1'b1, 16'hFFFF);               // one-byte label, widest buffer
    add_byte(8'hFF, 1'b0, 16'h0);
    add_byte(8'h00, 1'b0, 16'h0);
    add_byte(8'hFF, 1'b0, 16'h0);
    add_byte(8'hFF, 1'b0, 16'h0);
    add_byte(8'h00, 1'b0, 16'h0);
    add_byte(8'h00, 1'b0, 16'h0);
    add_byte(8'h03, 1'b1, 16'd100);                // dropped by the restart below
    add_byte(8'h78, 1'b0, 16'h0);
    add_byte(8'h00, 1'b1, 16'd5);                  // root name, exact fit
    add_byte(8'h00, 1'b0, 16'h0);
    add_byte(8'h00, 1'b0, 16'h0);
    add_byte(8'hFF, 1'b0, 16'h0);
    add_byte(8'hFF, 1'b0, 16'h0);
    add_byte(8'h00, 1'b1, 16'd4);                  // tail does not fit
    add_byte(8'h03, 1'b1, 16'd4);                  // label does not fit
    add_byte(8'h40, 1'b1, 16'hFFFF);               // label length 64
    add_byte(8'hC0, 1'b1, 16'hFFFF);               // compression pointer
    directed = stim_q.size();

    while (stim_q.size() < directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      add_question(Q_CLEAN);
      else if (pick < 73) add_question(Q_LONG);
      else if (pick < 83) add_question(Q_BAD_LABEL);
      else if (pick < 91) add_question(Q_CUT);
      else                add_question(Q_NOISE);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_q[i]) begin
      if (i == HOLD_AT_ITEM) hold_req = 1'b1;
      send_item(stim_q[i]);
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d byte transactions: %0d questions parsed, %0d name characters,",
             bytes_in, names_ok, chars);
    $display("%0d no-room and %0d bad-label endings, under random gaps and stalls.",
             no_room, bad_label);
    if (mismatches == 0 && pending == 0) begin
      $display("dns_question_parser test passed");
    end else begin
      $display("dns_question_parser test failed");
    end
    $finish;
  end

endmodule
